### hw/rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types and constants for the tick-driven I2C master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

	// Command codes carried by each tick.
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	// Bits per byte and the MSB select of a byte.
	localparam logic [3:0] BIT_TOTAL     = 4'd8;
	localparam int unsigned MSB_POS      = 7;
	localparam logic [7:0] HALF_RESET    = 8'd4;

	// Bus sequencer phases. Each phase is one segment of the bus waveform.
	typedef enum logic [4:0] {
		PH_IDLE = 5'd0,
		PH_ST0  = 5'd1,
		PH_ST1  = 5'd2,
		PH_ST2  = 5'd3,
		PH_SP0  = 5'd4,
		PH_SP1  = 5'd5,
		PH_SP2  = 5'd6,
		PH_W0   = 5'd7,
		PH_W1   = 5'd8,
		PH_WB0  = 5'd9,
		PH_WB1  = 5'd10,
		PH_WB2  = 5'd11,
		PH_WA0  = 5'd12,
		PH_WA1  = 5'd13,
		PH_WA2  = 5'd14,
		PH_WA3  = 5'd15,
		PH_RB0  = 5'd16,
		PH_RB1  = 5'd17,
		PH_RB2  = 5'd18,
		PH_RB3  = 5'd19,
		PH_RK0  = 5'd20,
		PH_RK1  = 5'd21,
		PH_RK2  = 5'd22,
		PH_RK3  = 5'd23
	} phase_t;

	// One input tick.
	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] wr_byte;
		logic       sda_in;
	} item_t;

	// One result per tick.
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       rd_valid;
		logic [7:0] rd_byte;
	} rslt_t;

	// Handshake status between the output stage and the top level.
	typedef struct packed {
		logic valid;
		logic can_load;
	} ostat_t;

endpackage

`default_nettype wire

### hw/rtl/i2c_master_bit_engine_top.sv
// Flow: an accepted input beat is loaded into the input register, then worked into
// the result register once that slot is free, so a full result slot can stall it.
// Throughput: one tick per clock while out_ready holds; the input register refills
// while the result register drains, so back-to-back beats flow without bubbles.
// Reset: arst_n clears both stages and returns the bus to idle with SCL and SDA
// high and driven; half_ticks returns to four.
// ----------------------------------------------------------------------------
// I2C master bit engine top level
// Tick-driven I2C master with valid/ready channels and one config register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] cmd,
	input  wire logic [7:0] wr_byte,
	input  wire logic       sda_in,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            scl_level,
	output logic            sda_level,
	output logic            sda_drive,
	output logic            busy_res,
	output logic            rd_valid,
	output logic [7:0]      rd_byte
);

	logic             valid_s1;
	i2cm_pkg::item_t  item_s1;
	logic             step;
	i2cm_pkg::rslt_t  rslt;
	i2cm_pkg::rslt_t  rslt_q;
	i2cm_pkg::ostat_t ostat;

	// A tick is worked when the input register holds one and the result slot is free.
	assign step     = valid_s1 && ostat.can_load;
	assign in_ready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{cmd: cmd, wr_byte: wr_byte, sda_in: sda_in};
		end
	end

	// Bus sequencer.
	i2cm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (step),
		.item        (item_s1),
		.rslt        (rslt)
	);

	// Result register.
	i2cm_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.rslt      (rslt),
		.out_ready (out_ready),
		.stat      (ostat),
		.rslt_q    (rslt_q)
	);

	assign out_valid = ostat.valid;
	assign scl_level = rslt_q.scl_level;
	assign sda_level = rslt_q.sda_level;
	assign sda_drive = rslt_q.sda_drive;
	assign busy_res  = rslt_q.busy_res;
	assign rd_valid  = rslt_q.rd_valid;
	assign rd_byte   = rslt_q.rd_byte;

endmodule

`default_nettype wire

### hw/rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Holds the bus state and works one tick per step into a result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_wr_en,
	input  wire logic [7:0]     cfg_wr_data,
	input  wire logic           step,
	input  wire i2cm_pkg::item_t item,
	output i2cm_pkg::rslt_t     rslt
);

	i2cm_pkg::phase_t phase_q;
	logic [7:0]       tick_q;
	logic [3:0]       bit_q;
	logic [7:0]       shift_q;
	logic             scl_q;
	logic             sda_q;
	logic             dir_q;
	logic [7:0]       half_ticks_q;

	// Values after command pickup and segment entry.
	i2cm_pkg::phase_t ph0;
	logic [7:0]       tick0;
	logic [3:0]       bit0;
	logic [7:0]       shift1;
	logic             scl1;
	logic             sda1;
	logic             dir1;

	// Next-state values.
	i2cm_pkg::phase_t phase_d;
	logic [7:0]       tick_d;
	logic [3:0]       bit_d;
	logic [3:0]       bit_inc;
	logic [7:0]       seg_raw;
	logic [7:0]       seg_len;
	logic [8:0]       cnt;
	logic             seg_done;
	logic             busy;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_ticks_q <= i2cm_pkg::HALF_RESET;
		end else if (cfg_wr_en) begin
			half_ticks_q <= cfg_wr_data;
		end
	end

	// Command pickup while idle, then the pin changes of a fresh segment.
	always_comb begin
		ph0    = phase_q;
		tick0  = tick_q;
		bit0   = bit_q;
		shift1 = shift_q;
		scl1   = scl_q;
		sda1   = sda_q;
		dir1   = dir_q;
		if (phase_q == i2cm_pkg::PH_IDLE) begin
			case (item.cmd)
				i2cm_pkg::CMD_START: begin
					ph0 = i2cm_pkg::PH_ST0; tick0 = '0; bit0 = '0;
				end
				i2cm_pkg::CMD_STOP: begin
					ph0 = i2cm_pkg::PH_SP0; tick0 = '0; bit0 = '0;
				end
				i2cm_pkg::CMD_WRITE: begin
					ph0 = i2cm_pkg::PH_W0; tick0 = '0; bit0 = '0;
					shift1 = item.wr_byte;
				end
				i2cm_pkg::CMD_READ: begin
					ph0 = i2cm_pkg::PH_RB0; tick0 = '0; bit0 = '0;
					shift1 = '0;
				end
				default: begin
				end
			endcase
		end
		if (tick0 == 8'd0) begin
			unique case (ph0)
				i2cm_pkg::PH_ST0: begin scl1 = 1'b1; sda1 = 1'b1; end
				i2cm_pkg::PH_ST1: sda1 = 1'b0;
				i2cm_pkg::PH_ST2: scl1 = 1'b0;
				i2cm_pkg::PH_SP1: scl1 = 1'b1;
				i2cm_pkg::PH_SP2: sda1 = 1'b1;
				i2cm_pkg::PH_W1:  scl1 = 1'b0;
				i2cm_pkg::PH_WB0: sda1 = shift1[i2cm_pkg::MSB_POS];
				i2cm_pkg::PH_WB1: scl1 = 1'b1;
				i2cm_pkg::PH_WB2: begin scl1 = 1'b0; shift1 = {shift1[6:0], 1'b0}; end
				i2cm_pkg::PH_WA0: sda1 = 1'b1;
				i2cm_pkg::PH_WA1: scl1 = 1'b1;
				i2cm_pkg::PH_WA2: scl1 = 1'b0;
				i2cm_pkg::PH_WA3: sda1 = 1'b0;
				i2cm_pkg::PH_RB0: begin scl1 = 1'b0; sda1 = 1'b1; dir1 = 1'b0; end
				i2cm_pkg::PH_RB1: scl1 = 1'b1;
				i2cm_pkg::PH_RB2: shift1 = {shift1[6:0], item.sda_in};
				i2cm_pkg::PH_RB3: scl1 = 1'b0;
				i2cm_pkg::PH_RK1: begin dir1 = 1'b1; sda1 = 1'b0; end
				i2cm_pkg::PH_RK2: scl1 = 1'b1;
				i2cm_pkg::PH_RK3: scl1 = 1'b0;
				default: begin
				end
			endcase
		end
	end

	// Segment length: half the period around the read sample point, never below one.
	assign busy     = (ph0 != i2cm_pkg::PH_IDLE);
	assign seg_raw  = (ph0 == i2cm_pkg::PH_RB1 || ph0 == i2cm_pkg::PH_RB2) ?
		{1'b0, half_ticks_q[7:1]} : half_ticks_q;
	assign seg_len  = (seg_raw == 8'd0) ? 8'd1 : seg_raw;
	assign cnt      = {1'b0, tick0} + 9'd1;
	assign seg_done = busy && (cnt >= {1'b0, seg_len});
	assign bit_inc  = bit0 + 4'd1;

	// Next phase, tick count and bit index.
	always_comb begin
		phase_d = ph0;
		tick_d  = tick0;
		bit_d   = bit0;
		if (busy) begin
			if (seg_done) begin
				tick_d = '0;
				unique case (ph0) inside
					i2cm_pkg::PH_ST2, i2cm_pkg::PH_SP2,
					i2cm_pkg::PH_WA3, i2cm_pkg::PH_RK3: phase_d = i2cm_pkg::PH_IDLE;
					i2cm_pkg::PH_WB2: begin
						bit_d   = bit_inc;
						phase_d = (bit_inc < i2cm_pkg::BIT_TOTAL) ?
							i2cm_pkg::PH_WB0 : i2cm_pkg::PH_WA0;
					end
					i2cm_pkg::PH_RB3: begin
						bit_d   = bit_inc;
						phase_d = (bit_inc < i2cm_pkg::BIT_TOTAL) ?
							i2cm_pkg::PH_RB0 : i2cm_pkg::PH_RK0;
					end
					default: phase_d = i2cm_pkg::phase_t'(ph0 + 5'd1);
				endcase
			end else begin
				tick_d = cnt[7:0];
			end
		end
	end

	// Result of this tick.
	always_comb begin
		rslt.scl_level = scl1;
		rslt.sda_level = sda1;
		rslt.sda_drive = dir1;
		rslt.busy_res  = busy;
		rslt.rd_valid  = seg_done && (ph0 == i2cm_pkg::PH_RK3);
		rslt.rd_byte   = (seg_done && (ph0 == i2cm_pkg::PH_RK3)) ? shift1 : 8'd0;
	end

	// State registers advance once per tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cm_pkg::PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			dir_q   <= 1'b1;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift1;
			scl_q   <= scl1;
			sda_q   <= sda1;
			dir_q   <= dir1;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/i2cm_out_stage.sv
// ----------------------------------------------------------------------------
// I2C master output stage
// Result register that holds a beat until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_out_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire i2cm_pkg::rslt_t rslt,
	input  wire logic            out_ready,
	output i2cm_pkg::ostat_t     stat,
	output i2cm_pkg::rslt_t      rslt_q
);

	logic valid_q;

	// The slot can take a new beat when empty or when it drains this cycle.
	assign stat.valid    = valid_q;
	assign stat.can_load = !valid_q || out_ready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			rslt_q <= rslt;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// I2C master port checker
// Watches the top-level ports and flags behavior the engine must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       scl_level,
	input wire logic       sda_level,
	input wire logic       sda_drive,
	input wire logic       busy_res,
	input wire logic       rd_valid,
	input wire logic [7:0] rd_byte
);

	// A completed read only happens inside a running command.
	a_rd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rd_valid |-> busy_res)
		else $error("read completion outside a busy command");

	// The read byte stays zero on beats that do not complete a read.
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rd_valid |-> rd_byte == 8'd0)
		else $error("read byte nonzero without completion");

	// SDA is released only while a read runs, never while idle.
	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sda_drive |-> busy_res)
		else $error("SDA released while idle");

	// A stalled result beat holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scl_level) &&
		$stable(sda_level) && $stable(sda_drive) && $stable(busy_res) &&
		$stable(rd_valid) && $stable(rd_byte))
		else $error("stalled result beat changed");

endmodule

bind i2c_master_bit_engine_top i2cm_checker u_i2cm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.scl_level (scl_level),
	.sda_level (sda_level),
	.sda_drive (sda_drive),
	.busy_res  (busy_res),
	.rd_valid  (rd_valid),
	.rd_byte   (rd_byte)
);

`default_nettype wire
